[rtl/class_file_stream_parser_assert.svh]
// Assertion macros for the class file stream parser.
`ifndef CLASS_FILE_STREAM_PARSER_ASSERT_SVH
`define CLASS_FILE_STREAM_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define CFP_ASSERT_IMPL(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define CFP_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CFP_ASSERT_IMPL(label, clk, rst, prop, msg)
`define CFP_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

[rtl/cfsp_pkg.sv]
// ----------------------------------------------------------------------------
// cfsp_pkg
// Types and constants shared by the class file stream parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cfsp_pkg;

   // Constant pool tags.
   localparam logic [7:0] TAG_UTF8            = 8'd1;
   localparam logic [7:0] TAG_INTEGER         = 8'd3;
   localparam logic [7:0] TAG_FLOAT           = 8'd4;
   localparam logic [7:0] TAG_LONG            = 8'd5;
   localparam logic [7:0] TAG_DOUBLE          = 8'd6;
   localparam logic [7:0] TAG_CLASS           = 8'd7;
   localparam logic [7:0] TAG_STRING          = 8'd8;
   localparam logic [7:0] TAG_FIELDREF        = 8'd9;
   localparam logic [7:0] TAG_METHODREF       = 8'd10;
   localparam logic [7:0] TAG_IFACE_METHODREF = 8'd11;
   localparam logic [7:0] TAG_NAME_AND_TYPE   = 8'd12;
   localparam logic [7:0] TAG_METHOD_HANDLE   = 8'd15;
   localparam logic [7:0] TAG_METHOD_TYPE     = 8'd16;
   localparam logic [7:0] TAG_DYNAMIC         = 8'd17;
   localparam logic [7:0] TAG_INVOKE_DYNAMIC  = 8'd18;
   localparam logic [7:0] TAG_MODULE          = 8'd19;
   localparam logic [7:0] TAG_PACKAGE         = 8'd20;

   // Parse phases; the code is also the token kind.
   typedef enum logic [4:0] {
      PH_MAGIC, PH_MINOR, PH_MAJOR, PH_CPCOUNT, PH_CPTAG, PH_CPFIRST,
      PH_CPSECOND, PH_CPU4, PH_CPU8, PH_REFKIND, PH_UTFLEN, PH_UTFBYTE,
      PH_ACCESS, PH_THIS, PH_SUPER, PH_IFCOUNT, PH_IFACE, PH_FCOUNT,
      PH_MCOUNT, PH_MACCESS, PH_MNAME, PH_MDESC, PH_MATTRCOUNT,
      PH_CATTRCOUNT, PH_ANAME, PH_ALEN, PH_ABYTE
   } phase_type;

   localparam logic [1:0] SEC_HEADER = 2'd0;
   localparam logic [1:0] SEC_FIELDS = 2'd1;
   localparam logic [1:0] SEC_METHODS = 2'd2;
   localparam logic [1:0] SEC_CLASS = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [63:0] field_value;
      logic [15:0] entry_number;
      logic [15:0] attribute_number;
      logic [1:0]  section;
      logic        class_done;
      logic        parse_error;
   } rsp_type;

   // Number of bytes in the field of each phase.
   function automatic logic [3:0] phase_bytes(input phase_type ph);
      case (ph)
         PH_MAGIC, PH_CPU4, PH_ALEN: phase_bytes = 4'd4;
         PH_CPU8: phase_bytes = 4'd8;
         PH_CPTAG, PH_REFKIND, PH_UTFBYTE, PH_ABYTE: phase_bytes = 4'd1;
         default: phase_bytes = 4'd2;
      endcase
   endfunction

endpackage

[rtl/cfsp_out_reg.sv]
// ----------------------------------------------------------------------------
// cfsp_out_reg
// Two-entry output buffer: holds results so the input side waits on a
// stalled receiver only when both entries are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfsp_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  cfsp_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output cfsp_pkg::rsp_type out_data
);
   import cfsp_pkg::*;

   rsp_type main_ff, main_in, skid_ff, skid_in;
   logic    main_vld_ff, main_vld_in, skid_vld_ff, skid_vld_in;

   assign in_ready  = !skid_vld_ff;
   assign out_valid = main_vld_ff;
   assign out_data  = main_ff;

   // Main register feeds the port; the skid catches a request during a stall.
   always_comb begin
      main_in = main_ff;
      main_vld_in = main_vld_ff;
      skid_in = skid_ff;
      skid_vld_in = skid_vld_ff;
      if (!main_vld_ff || out_ready) begin
         if (skid_vld_ff) begin
            main_in = skid_ff;
            main_vld_in = 1'b1;
            skid_vld_in = 1'b0;
         end else begin
            main_in = in_data;
            main_vld_in = in_valid;
         end
      end else if (in_valid && !skid_vld_ff) begin
         skid_in = in_data;
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
      if (reset) begin
         main_vld_ff <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         main_vld_ff <= main_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

endmodule

[rtl/cfsp_parser.sv]
// ----------------------------------------------------------------------------
// cfsp_parser
// Parse state and per-byte decode: one byte in, at most one token out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cfsp_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  cfsp_pkg::req_type byte_data,
   output logic              tok_valid,
   output cfsp_pkg::rsp_type tok_data
);
   import cfsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [2:0]  bif_ff, bif_in;
   logic [63:0] shift_ff, shift_in;
   logic [7:0]  tag_ff, tag_in;
   logic [15:0] pidx_ff, pidx_in, pcnt_ff, pcnt_in;
   logic [15:0] midx_ff, midx_in, mcnt_ff, mcnt_in;
   logic [15:0] aidx_ff, aidx_in, acnt_ff, acnt_in;
   logic [31:0] left_ff, left_in;
   logic        err_ff, err_in, fin_ff, fin_in;
   logic [1:0]  sec_ff, sec_in;

   // Effective state after an optional file start.
   phase_type   ph;
   logic [2:0]  bif;
   logic [63:0] sh, v;
   logic [7:0]  tag;
   logic [15:0] pidx, pcnt, midx, mcnt, aidx, acnt;
   logic [31:0] left, v32, left_dec;
   logic        err, fin;
   logic [1:0]  sec;
   logic        done_now, bad_tag;
   logic [16:0] pnext;
   logic [15:0] midx_inc, aidx_inc;
   logic [15:0] entry, attr;

   always_comb begin
      if (byte_data.file_start) begin
         ph = PH_MAGIC; bif = '0; sh = '0; tag = '0; pidx = 16'd1; pcnt = '0;
         midx = '0; mcnt = '0; aidx = '0; acnt = '0; left = '0;
         err = 1'b0; fin = 1'b0; sec = SEC_HEADER;
      end else begin
         ph = phase_ff; bif = bif_ff; sh = shift_ff; tag = tag_ff;
         pidx = pidx_ff; pcnt = pcnt_ff; midx = midx_ff; mcnt = mcnt_ff;
         aidx = aidx_ff; acnt = acnt_ff; left = left_ff;
         err = err_ff; fin = fin_ff; sec = sec_ff;
      end
   end

   // Next-state decode of one byte.
   always_comb begin
      phase_in = ph; bif_in = bif; tag_in = tag; pidx_in = pidx; pcnt_in = pcnt;
      midx_in = midx; mcnt_in = mcnt; aidx_in = aidx; acnt_in = acnt;
      left_in = left; err_in = err; fin_in = fin; sec_in = sec;
      v = {sh[55:0], byte_data.data_byte};
      shift_in = sh;
      v32 = v[31:0];
      left_dec = left - 32'd1;
      midx_inc = midx + 16'd1;
      aidx_inc = aidx + 16'd1;
      pnext = {1'b0, pidx} + ((tag == TAG_LONG || tag == TAG_DOUBLE)
              ? 17'd2 : 17'd1);
      done_now = 1'b0;
      bad_tag = 1'b0;
      tok_valid = 1'b0;
      entry = '0;
      attr = '0;
      if (ph == PH_CPTAG || ph == PH_CPFIRST || ph == PH_CPSECOND || ph == PH_CPU4
          || ph == PH_CPU8 || ph == PH_REFKIND || ph == PH_UTFLEN
          || ph == PH_UTFBYTE)
         entry = pidx;
      else if (ph == PH_IFACE || ph == PH_MACCESS || ph == PH_MNAME
               || ph == PH_MDESC || ph == PH_MATTRCOUNT)
         entry = midx;
      else if (ph == PH_ANAME || ph == PH_ALEN || ph == PH_ABYTE) begin
         entry = (sec == SEC_CLASS) ? 16'd0 : midx;
         attr = aidx;
      end
      if (byte_valid && !fin && !err) begin
         shift_in = v;
         if ({1'b0, bif} + 4'd1 < phase_bytes(ph)) begin
            bif_in = bif + 3'd1;
         end else begin
            tok_valid = 1'b1;
            shift_in = '0;
            bif_in = '0;
            case (ph)
               PH_MAGIC: phase_in = PH_MINOR;
               PH_MINOR: phase_in = PH_MAJOR;
               PH_MAJOR: phase_in = PH_CPCOUNT;
               PH_CPCOUNT: begin
                  pcnt_in = v32[15:0];
                  pidx_in = 16'd1;
                  phase_in = (16'd1 < v32[15:0]) ? PH_CPTAG : PH_ACCESS;
               end
               PH_CPTAG: begin
                  tag_in = v32[7:0];
                  case (v32[7:0])
                     TAG_CLASS, TAG_MODULE, TAG_PACKAGE,
                     TAG_STRING, TAG_METHOD_TYPE, TAG_FIELDREF,
                     TAG_METHODREF, TAG_IFACE_METHODREF,
                     TAG_NAME_AND_TYPE, TAG_DYNAMIC,
                     TAG_INVOKE_DYNAMIC: phase_in = PH_CPFIRST;
                     TAG_INTEGER, TAG_FLOAT: phase_in = PH_CPU4;
                     TAG_LONG, TAG_DOUBLE: phase_in = PH_CPU8;
                     TAG_METHOD_HANDLE: phase_in = PH_REFKIND;
                     TAG_UTF8: phase_in = PH_UTFLEN;
                     default: begin
                        err_in = 1'b1;
                        bad_tag = 1'b1;
                     end
                  endcase
               end
               PH_REFKIND: phase_in = PH_CPFIRST;
               PH_ACCESS: phase_in = PH_THIS;
               PH_THIS: phase_in = PH_SUPER;
               PH_SUPER: phase_in = PH_IFCOUNT;
               PH_IFCOUNT: begin
                  mcnt_in = v32[15:0];
                  midx_in = '0;
                  phase_in = (v32 == 32'd0) ? PH_FCOUNT : PH_IFACE;
               end
               PH_IFACE: begin
                  midx_in = midx_inc;
                  if (midx_inc >= mcnt) phase_in = PH_FCOUNT;
               end
               PH_FCOUNT, PH_MCOUNT: begin
                  sec_in = (ph == PH_FCOUNT) ? SEC_FIELDS : SEC_METHODS;
                  mcnt_in = v32[15:0];
                  midx_in = '0;
                  if (v32 == 32'd0)
                     phase_in = (ph == PH_FCOUNT) ? PH_MCOUNT : PH_CATTRCOUNT;
                  else
                     phase_in = PH_MACCESS;
               end
               PH_MACCESS: phase_in = PH_MNAME;
               PH_MNAME: phase_in = PH_MDESC;
               PH_MDESC: phase_in = PH_MATTRCOUNT;
               PH_CATTRCOUNT: begin
                  sec_in = SEC_CLASS;
                  acnt_in = v32[15:0];
                  aidx_in = '0;
                  if (v32 == 32'd0) begin
                     fin_in = 1'b1;
                     done_now = 1'b1;
                  end else phase_in = PH_ANAME;
               end
               PH_ANAME: phase_in = PH_ALEN;
               default: ;
            endcase
            // Pool entry completion.
            if ((ph == PH_CPFIRST && !(tag == TAG_FIELDREF
                 || tag == TAG_METHODREF || tag == TAG_IFACE_METHODREF
                 || tag == TAG_NAME_AND_TYPE || tag == TAG_DYNAMIC
                 || tag == TAG_INVOKE_DYNAMIC))
                || ph == PH_CPSECOND || ph == PH_CPU4 || ph == PH_CPU8
                || (ph == PH_UTFLEN && v32 == 32'd0)
                || (ph == PH_UTFBYTE && left_dec == 32'd0)) begin
               pidx_in = pnext[16] ? 16'hFFFF : pnext[15:0];
               phase_in = ((pnext[16] ? 16'hFFFF : pnext[15:0]) < pcnt)
                          ? PH_CPTAG : PH_ACCESS;
            end else if (ph == PH_CPFIRST) begin
               phase_in = PH_CPSECOND;
            end
            if (ph == PH_UTFLEN) begin
               left_in = v32;
               if (v32 != 32'd0) phase_in = PH_UTFBYTE;
            end
            if (ph == PH_UTFBYTE || ph == PH_ABYTE) left_in = left_dec;
            if (ph == PH_ALEN) begin
               left_in = v32;
               if (v32 != 32'd0) phase_in = PH_ABYTE;
            end
            if (ph == PH_MATTRCOUNT) begin
               acnt_in = v32[15:0];
               aidx_in = '0;
            end
            // Attribute or member completion.
            if ((ph == PH_ALEN && v32 == 32'd0)
                || (ph == PH_ABYTE && left_dec == 32'd0)) begin
               aidx_in = aidx_inc;
               if (aidx_inc < acnt) phase_in = PH_ANAME;
               else if (sec == SEC_CLASS) begin
                  fin_in = 1'b1;
                  done_now = 1'b1;
               end else begin
                  midx_in = midx_inc;
                  if (midx_inc >= mcnt)
                     phase_in = (sec == SEC_FIELDS) ? PH_MCOUNT : PH_CATTRCOUNT;
                  else phase_in = PH_MACCESS;
               end
            end
            if (ph == PH_MATTRCOUNT) begin
               if (v32 == 32'd0) begin
                  midx_in = midx_inc;
                  if (midx_inc >= mcnt)
                     phase_in = (sec == SEC_FIELDS) ? PH_MCOUNT : PH_CATTRCOUNT;
                  else phase_in = PH_MACCESS;
               end else phase_in = PH_ANAME;
            end
         end
      end
      tok_data.token_kind = ph;
      tok_data.field_value = v;
      tok_data.entry_number = entry;
      tok_data.attribute_number = attr;
      tok_data.section = sec_in;
      tok_data.class_done = done_now;
      tok_data.parse_error = bad_tag;
   end

   // Apply state only when a request is accepted.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; bif_ff <= '0; shift_ff <= '0; tag_ff <= '0;
         pidx_ff <= 16'd1; pcnt_ff <= '0; midx_ff <= '0; mcnt_ff <= '0;
         aidx_ff <= '0; acnt_ff <= '0; left_ff <= '0; err_ff <= 1'b0;
         fin_ff <= 1'b0; sec_ff <= SEC_HEADER;
      end else if (byte_valid) begin
         phase_ff <= phase_in; bif_ff <= bif_in; shift_ff <= shift_in;
         tag_ff <= tag_in; pidx_ff <= pidx_in; pcnt_ff <= pcnt_in;
         midx_ff <= midx_in; mcnt_ff <= mcnt_in; aidx_ff <= aidx_in;
         acnt_ff <= acnt_in; left_ff <= left_in; err_ff <= err_in;
         fin_ff <= fin_in; sec_ff <= sec_in;
      end
   end

endmodule

[rtl/class_file_stream_parser.sv]
// ----------------------------------------------------------------------------
// class_file_stream_parser
// Streaming class file parser producing one token per completed field.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one class file byte per request, most
//   significant byte first; file_start on a request restarts the parse.
//   The rsp_ channel carries one token per completed field, with indexes,
//   section, end-of-class and error flags. Bytes inside a multi-byte field,
//   after the end of the class or after a bad pool tag produce no token.
//   Throughput is one request per cycle while req_ready is high; each
//   token is registered in the output buffer before it reaches rsp_data.
//   A two-entry output buffer absorbs receiver stalls; req_ready drops
//   only when both entries are full.
//   Reset clears the parse state to expect the magic number and empties
//   the output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module class_file_stream_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cfsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cfsp_pkg::rsp_type rsp_data
);
   import cfsp_pkg::*;

   logic    accept, tok_valid;
   rsp_type tok_data;

   assign accept = req_valid && req_ready;

   cfsp_parser u_parser (
      .clock(clock), .reset(reset), .byte_valid(accept), .byte_data(req_data),
      .tok_valid(tok_valid), .tok_data(tok_data)
   );

   cfsp_out_reg u_out (
      .clock(clock), .reset(reset), .in_valid(tok_valid), .in_ready(req_ready),
      .in_data(tok_data), .out_valid(rsp_valid), .out_ready(rsp_ready),
      .out_data(rsp_data)
   );

`include "class_file_stream_parser_assert.svh"

   // A token never reports both an error and the end of the class.
   `CFP_ASSERT_IMPL(a_err_done, clock, reset, rsp_valid |-> !(rsp_data.parse_error && rsp_data.class_done), "error and done together")
   // An error token is always a pool tag token.
   `CFP_ASSERT_IMPL(a_err_tag, clock, reset, (rsp_valid && rsp_data.parse_error) |-> (rsp_data.token_kind == PH_CPTAG), "error on non-tag token")
   // Attribute numbers appear only on attribute tokens.
   `CFP_ASSERT_IMPL(a_attr_kind, clock, reset, (rsp_valid && rsp_data.attribute_number != 16'd0) |-> (rsp_data.token_kind == PH_ANAME || rsp_data.token_kind == PH_ALEN || rsp_data.token_kind == PH_ABYTE), "attribute number on wrong token")

endmodule
